@@ design/dhqp_pkg.sv @@
// ----------------------------------------------------------------------------
// dhqp_pkg
// Shared types and constants of the DNS header and question parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dhqp_pkg;

    // default limit on the question name length
    localparam int MAX_NAME_DEF = 256;

    // width of the name length check sum (covers the default name limit)
    localparam int SUM_W = 10;

    // queue between parser front and output back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // last header byte index and type/class byte count of a message
    localparam logic [15:0] HEADER_LAST_IDX = 16'd11;
    localparam logic [2:0]  TYPE_CLASS_BYTES = 3'd4;

    // output word width: 154 payload bits padded to whole bytes
    localparam int OUT_W = 160;

    // summary status codes
    typedef enum logic [1:0] {
        ST_OK_QUESTION = 2'd0,
        ST_OK_NO_QUEST = 2'd1,
        ST_SHORT_HDR   = 2'd2,
        ST_TRUNCATED   = 2'd3
    } t_status;

    // parse phase of the current message
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_LEN    = 3'd1,
        PH_DATA   = 3'd2,
        PH_TRAIL  = 3'd3,
        PH_DONE   = 3'd4,
        PH_SKIP   = 3'd5
    } t_phase;

    // end-of-message summary
    typedef struct packed {
        logic [15:0] ident;
        logic [15:0] hdr_flags;
        logic [15:0] question_count;
        logic [15:0] answer_count;
        logic [15:0] authority_count;
        logic [15:0] additional_count;
        logic [15:0] query_type;
        logic [15:0] query_class;
        t_status     status;
        logic [15:0] packet_length;
    } t_summary;

    // one queue entry: an optional name character, then an optional summary
    typedef struct packed {
        logic       has_char;
        logic [7:0] name_char;
        logic       has_sum;
        t_summary   sum;
    } t_entry;

endpackage

`default_nettype wire

@@ design/dhqp_front.sv @@
// ----------------------------------------------------------------------------
// dhqp_front
// Byte parser: tracks header, name labels and type/class, one byte a cycle
// while bytes are accepted, and pushes character and summary work into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dhqp_front #(
    parameter int MAX_NAME = dhqp_pkg::MAX_NAME_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [7:0]       i_byte,
    input  wire logic             i_last,
    output dhqp_pkg::t_entry      o_entry,
    output logic                  o_push
);

    localparam int NL_W = $clog2(MAX_NAME);
    localparam logic [7:0] DOT = 8'h2E;
    localparam logic [dhqp_pkg::SUM_W-1:0] LIMIT = dhqp_pkg::SUM_W'(MAX_NAME);

    // parser state
    logic [15:0]       r_byte_count, n_byte_count;
    logic [15:0]       r_hdr [6];
    logic [15:0]       n_hdr [6];
    dhqp_pkg::t_phase  r_phase, n_phase;
    logic [7:0]        r_label_rem, n_label_rem;
    logic [NL_W-1:0]   r_name_len, n_name_len;
    logic [31:0]       r_tc, n_tc;
    logic [2:0]        r_trail_cnt, n_trail_cnt;
    logic              r_failed, n_failed;

    logic [dhqp_pkg::SUM_W-1:0] len_sum;
    logic                       too_long;
    logic [2:0]                 widx;

    // name length check for a new label
    assign len_sum  = dhqp_pkg::SUM_W'(r_name_len) + dhqp_pkg::SUM_W'(i_byte)
                      + dhqp_pkg::SUM_W'(1);
    assign too_long = (len_sum >= LIMIT);
    assign widx     = r_byte_count[3:1];

    // next state
    always_comb begin
        n_byte_count = (r_byte_count == 16'hFFFF) ? r_byte_count : r_byte_count + 16'd1;
        n_hdr        = r_hdr;
        n_phase      = r_phase;
        n_label_rem  = r_label_rem;
        n_name_len   = r_name_len;
        n_tc         = r_tc;
        n_trail_cnt  = r_trail_cnt;
        n_failed     = r_failed;
        case (r_phase)
            dhqp_pkg::PH_HEADER: begin
                if (!r_byte_count[0]) begin
                    n_hdr[widx] = {i_byte, 8'h00};
                end else begin
                    n_hdr[widx] = {r_hdr[widx][15:8], i_byte};
                end
                if (r_byte_count == dhqp_pkg::HEADER_LAST_IDX) begin
                    n_phase = (r_hdr[2] != 16'd0) ? dhqp_pkg::PH_LEN : dhqp_pkg::PH_SKIP;
                end
            end
            dhqp_pkg::PH_LEN: begin
                if (i_byte == 8'd0) begin
                    if (r_name_len == '0) begin
                        n_failed = 1'b1;
                        n_phase  = dhqp_pkg::PH_SKIP;
                    end else begin
                        n_phase  = dhqp_pkg::PH_TRAIL;
                    end
                end else if (too_long) begin
                    n_failed = 1'b1;
                    n_phase  = dhqp_pkg::PH_SKIP;
                end else begin
                    n_name_len  = len_sum[NL_W-1:0];
                    n_label_rem = i_byte;
                    n_phase     = dhqp_pkg::PH_DATA;
                end
            end
            dhqp_pkg::PH_DATA: begin
                n_label_rem = r_label_rem - 8'd1;
                if (r_label_rem == 8'd1) begin
                    n_phase = dhqp_pkg::PH_LEN;
                end
            end
            dhqp_pkg::PH_TRAIL: begin
                n_tc        = {r_tc[23:0], i_byte};
                n_trail_cnt = r_trail_cnt + 3'd1;
                if (n_trail_cnt >= dhqp_pkg::TYPE_CLASS_BYTES) begin
                    n_phase = dhqp_pkg::PH_DONE;
                end
            end
            default: begin
            end
        endcase
    end

    // queue entry built from the updated state
    always_comb begin
        o_entry = '0;
        // dot before every label but the first, or a label character
        if (r_phase == dhqp_pkg::PH_LEN && i_byte != 8'd0 && !too_long
            && r_name_len != '0) begin
            o_entry.has_char  = 1'b1;
            o_entry.name_char = DOT;
        end else if (r_phase == dhqp_pkg::PH_DATA) begin
            o_entry.has_char  = 1'b1;
            o_entry.name_char = i_byte;
        end
        // summary on the last byte
        o_entry.has_sum           = i_last;
        o_entry.sum.packet_length = n_byte_count;
        if (n_phase == dhqp_pkg::PH_HEADER) begin
            o_entry.sum.status = dhqp_pkg::ST_SHORT_HDR;
        end else begin
            o_entry.sum.ident            = n_hdr[0];
            o_entry.sum.hdr_flags        = n_hdr[1];
            o_entry.sum.question_count   = n_hdr[2];
            o_entry.sum.answer_count     = n_hdr[3];
            o_entry.sum.authority_count  = n_hdr[4];
            o_entry.sum.additional_count = n_hdr[5];
            if (n_hdr[2] == 16'd0) begin
                o_entry.sum.status = dhqp_pkg::ST_OK_NO_QUEST;
            end else if (!n_failed && n_phase == dhqp_pkg::PH_DONE) begin
                o_entry.sum.status      = dhqp_pkg::ST_OK_QUESTION;
                o_entry.sum.query_type  = n_tc[31:16];
                o_entry.sum.query_class = n_tc[15:0];
            end else begin
                o_entry.sum.status = dhqp_pkg::ST_TRUNCATED;
            end
        end
        o_push = i_accept && (o_entry.has_char || i_last);
    end

    // state registers, cleared at reset and after each last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            r_byte_count <= '0;
            for (int i = 0; i < 6; i++) begin
                r_hdr[i] <= '0;
            end
            r_phase     <= dhqp_pkg::PH_HEADER;
            r_label_rem <= '0;
            r_name_len  <= '0;
            r_tc        <= '0;
            r_trail_cnt <= '0;
            r_failed    <= 1'b0;
        end else if (i_accept) begin
            r_byte_count <= n_byte_count;
            r_hdr        <= n_hdr;
            r_phase      <= n_phase;
            r_label_rem  <= n_label_rem;
            r_name_len   <= n_name_len;
            r_tc         <= n_tc;
            r_trail_cnt  <= n_trail_cnt;
            r_failed     <= n_failed;
        end
    end

endmodule

`default_nettype wire

@@ design/dhqp_queue.sv @@
// ----------------------------------------------------------------------------
// dhqp_queue
// Short FIFO of parser entries between the front and the output back.
// ----------------------------------------------------------------------------
`default_nettype none

module dhqp_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire dhqp_pkg::t_entry  i_entry,
    output logic                   o_full,
    output logic                   o_valid,
    output dhqp_pkg::t_entry       o_entry,
    input  wire logic              i_pop
);

    dhqp_pkg::t_entry                r_mem [dhqp_pkg::QUEUE_DEPTH];
    logic [dhqp_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [dhqp_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [dhqp_pkg::QCNT_W-1:0]     r_count;

    assign o_full  = (r_count == dhqp_pkg::QCNT_W'(dhqp_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/dhqp_back.sv @@
// ----------------------------------------------------------------------------
// dhqp_back
// Output stage: turns queue entries into output words, a character word
// first and then a summary word, through a registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module dhqp_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire dhqp_pkg::t_entry           i_entry,
    output logic                            o_pop,
    output logic                            o_tvalid,
    input  wire logic                       i_tready,
    output logic [dhqp_pkg::OUT_W-1:0]      o_tdata,
    output logic                            o_tlast
);

    logic                          r_valid;
    logic                          r_last;
    logic [dhqp_pkg::OUT_W-1:0]    r_data;
    logic                          r_char_done;

    logic                          load;
    logic                          emit_char;
    logic [dhqp_pkg::OUT_W-1:0]    n_data;

    assign load      = i_valid && (!r_valid || i_tready);
    assign emit_char = i_entry.has_char && !r_char_done;
    // an entry leaves once its final word is loaded
    assign o_pop     = load && (!emit_char || !i_entry.has_sum);

    // word packing, first field in the lowest bits
    always_comb begin
        if (emit_char) begin
            n_data = {{(dhqp_pkg::OUT_W-8){1'b0}}, i_entry.name_char};
        end else begin
            n_data = {6'd0,
                      i_entry.sum.packet_length,
                      i_entry.sum.status,
                      i_entry.sum.query_class,
                      i_entry.sum.query_type,
                      i_entry.sum.additional_count,
                      i_entry.sum.authority_count,
                      i_entry.sum.answer_count,
                      i_entry.sum.question_count,
                      i_entry.sum.hdr_flags,
                      i_entry.sum.ident,
                      8'd0};
        end
    end

    // output register and entry progress
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_char_done <= 1'b0;
        end else begin
            if (load) begin
                r_valid     <= 1'b1;
                r_char_done <= emit_char && i_entry.has_sum;
            end else if (i_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= n_data;
            r_last <= !emit_char;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tlast  = r_last;

endmodule

`default_nettype wire

@@ design/dns_header_question_parser_top.sv @@
// ----------------------------------------------------------------------------
// dns_header_question_parser_top
// DNS message header and first-question parser on byte streams.
// ----------------------------------------------------------------------------
// Input: one payload byte per word on s_axis (tdata[7:0]); s_axis_tlast marks
// the final byte of a message. Output on m_axis: a name character word
// (m_axis_tlast low, character in tdata[7:0]) for each character or dot of the
// first question name, and one summary word per message (m_axis_tlast high)
// with header words, query type and class, status and byte count.
// Throughput: one byte per cycle while the queue is not full. A byte gives at
// most two output words (a character or dot, then a summary); the output side
// drains one word per cycle while the receiver is ready, so such an entry stays
// in the four-entry queue until both its words are loaded.
// A word goes from the parser into the queue at the accept edge and then into
// the output register before it appears on m_axis.
// Reset clears the parser state, empties the queue and drops m_axis_tvalid.
// When the receiver stalls, the output word holds; the queue fills and then
// s_axis_tready goes low until space frees.
// ----------------------------------------------------------------------------
`default_nettype none

module dns_header_question_parser_top #(
    parameter int MAX_NAME = dhqp_pkg::MAX_NAME_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [7:0]                 s_axis_tdata,   // [7:0] data_byte
    input  wire logic                       s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // [7:0] name_char, [23:8] ident, [39:24] hdr_flags, [55:40] question_count,
    // [71:56] answer_count, [87:72] authority_count, [103:88] additional_count,
    // [119:104] query_type, [135:120] query_class, [137:136] status,
    // [153:138] packet_length, [159:154] zero
    output logic [dhqp_pkg::OUT_W-1:0]      m_axis_tdata,
    output logic                            m_axis_tlast    // kind
);

    logic              accept;
    logic              q_full;
    logic              push;
    dhqp_pkg::t_entry  f_entry;
    logic              q_valid;
    dhqp_pkg::t_entry  q_entry;
    logic              pop;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // parser front
    dhqp_front #(
        .MAX_NAME (MAX_NAME)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_entry  (f_entry),
        .o_push   (push)
    );

    // decoupling queue
    dhqp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (f_entry),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (q_entry),
        .i_pop   (pop)
    );

    // output back
    dhqp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_entry  (q_entry),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

@@ tb/tb_dns_header_question_parser_top.sv @@
// ----------------------------------------------------------------------------
// tb_dns_header_question_parser_top
// Self-checking bench for the DNS header and first-question parser.
// ----------------------------------------------------------------------------
// Payload bytes are queued by a stimulus process and fed by a clocked driver.
// On every accepted byte a local parser model updates its own copy of the
// header, name and trailer state and queues the words the block should send.
// A clocked monitor pops one expected word per output word and compares it
// field by field. The run opens with directed payloads (short header, no
// question, empty name, over-long label, pointer byte read as label length,
// truncation, trailing bytes) and then runs random payloads, mostly
// well-formed, under four idling mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_dns_header_question_parser_top;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RAND_PER_PHASE = 450;

    // one input word: payload byte and last-byte mark
    typedef struct packed {
        logic [7:0] data;
        logic       lst;
    } t_pay_byte;

    // one output word as the block should send it
    typedef struct packed {
        logic              kind;
        logic [7:0]        ch;
        logic [15:0]       ident;
        logic [15:0]       flags;
        logic [15:0]       qd;
        logic [15:0]       an;
        logic [15:0]       ns;
        logic [15:0]       ar;
        logic [15:0]       qtype;
        logic [15:0]       qclass;
        dhqp_pkg::t_status st;
        logic [15:0]       plen;
    } t_dns_word;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic                s_axis_tlast = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // [7:0] name_char, [23:8] ident, [39:24] hdr_flags, [55:40] question_count,
    // [71:56] answer_count, [87:72] authority_count, [103:88] additional_count,
    // [119:104] query_type, [135:120] query_class, [137:136] status,
    // [153:138] packet_length
    logic [dhqp_pkg::OUT_W-1:0] m_axis_tdata;
    logic                m_axis_tlast;

    t_pay_byte           pending_bytes[$];
    t_pay_byte           cur_byte;
    t_dns_word           expected_words[$];
    logic [7:0]          pkt_buf[$];
    int                  n_pushed = 0;
    int                  n_errors = 0;
    int                  cycles = 0;
    int                  send_idle_pct = 0;
    int                  stall_pct = 0;

    // parser model state
    logic [15:0]         p_count;
    logic [15:0]         p_hdr[6];
    dhqp_pkg::t_phase    p_phase;
    logic [7:0]          p_lab_rem;
    int                  p_name_len;
    logic [31:0]         p_tc;
    logic [2:0]          p_tc_cnt;
    logic                p_fail;

    dns_header_question_parser_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------------
    task automatic clear_parse;
        p_count    = 16'h0000;
        for (int k = 0; k < 6; k++) p_hdr[k] = 16'h0000;
        p_phase    = dhqp_pkg::PH_HEADER;
        p_lab_rem  = 8'h00;
        p_name_len = 0;
        p_tc       = 32'h0;
        p_tc_cnt   = 3'd0;
        p_fail     = 1'b0;
    endtask

    task automatic push_char(input logic [7:0] c);
        t_dns_word w;
        w = '0;
        w.ch = c;
        expected_words.push_back(w);
    endtask

    // advance the model by one payload byte, queue the words it causes
    task automatic parse_byte(input logic [7:0] b, input logic lst);
        logic [15:0] idx;
        t_dns_word   w;
        idx = p_count;
        if (p_count != 16'hFFFF) p_count = p_count + 16'd1;

        case (p_phase)
            dhqp_pkg::PH_HEADER: begin
                if (!idx[0]) p_hdr[idx[3:1]] = {b, 8'h00};
                else         p_hdr[idx[3:1]][7:0] = b;
                if (idx >= dhqp_pkg::HEADER_LAST_IDX)
                    p_phase = (p_hdr[2] != 16'h0000) ? dhqp_pkg::PH_LEN
                                                     : dhqp_pkg::PH_SKIP;
            end
            dhqp_pkg::PH_LEN: begin
                if (b == 8'h00) begin
                    if (p_name_len == 0) begin
                        p_fail  = 1'b1;
                        p_phase = dhqp_pkg::PH_SKIP;
                    end else begin
                        p_phase = dhqp_pkg::PH_TRAIL;
                    end
                end else if (p_name_len + int'(b) + 1 >= dhqp_pkg::MAX_NAME_DEF) begin
                    p_fail  = 1'b1;
                    p_phase = dhqp_pkg::PH_SKIP;
                end else begin
                    // dot between labels
                    if (p_name_len != 0) push_char(8'h2E);
                    p_name_len = p_name_len + int'(b) + 1;
                    p_lab_rem  = b;
                    p_phase    = dhqp_pkg::PH_DATA;
                end
            end
            dhqp_pkg::PH_DATA: begin
                push_char(b);
                p_lab_rem = p_lab_rem - 8'd1;
                if (p_lab_rem == 8'h00) p_phase = dhqp_pkg::PH_LEN;
            end
            dhqp_pkg::PH_TRAIL: begin
                p_tc     = {p_tc[23:0], b};
                p_tc_cnt = p_tc_cnt + 3'd1;
                if (p_tc_cnt >= dhqp_pkg::TYPE_CLASS_BYTES) p_phase = dhqp_pkg::PH_DONE;
            end
            default: ;
        endcase

        // end-of-payload summary
        if (lst) begin
            w = '0;
            w.kind = 1'b1;
            if (p_phase == dhqp_pkg::PH_HEADER) begin
                w.st = dhqp_pkg::ST_SHORT_HDR;
            end else begin
                w.ident = p_hdr[0];
                w.flags = p_hdr[1];
                w.qd    = p_hdr[2];
                w.an    = p_hdr[3];
                w.ns    = p_hdr[4];
                w.ar    = p_hdr[5];
                if (p_hdr[2] == 16'h0000)
                    w.st = dhqp_pkg::ST_OK_NO_QUEST;
                else if (!p_fail && p_phase == dhqp_pkg::PH_DONE)
                    w.st = dhqp_pkg::ST_OK_QUESTION;
                else
                    w.st = dhqp_pkg::ST_TRUNCATED;
            end
            if (w.st == dhqp_pkg::ST_OK_QUESTION) begin
                w.qtype  = p_tc[31:16];
                w.qclass = p_tc[15:0];
            end
            w.plen = p_count;
            expected_words.push_back(w);
            clear_parse();
        end
    endtask

    // ------------------------------------------------------------------------
    // Payload building
    // ------------------------------------------------------------------------
    task automatic add16(input logic [15:0] v);
        pkt_buf.push_back(v[15:8]);
        pkt_buf.push_back(v[7:0]);
    endtask

    task automatic add_header(input logic [15:0] id, input logic [15:0] fl,
                              input logic [15:0] qd, input logic [15:0] an,
                              input logic [15:0] ns, input logic [15:0] ar);
        add16(id);
        add16(fl);
        add16(qd);
        add16(an);
        add16(ns);
        add16(ar);
    endtask

    task automatic add_rand_header(input logic [15:0] qd);
        add_header(16'($urandom), 16'($urandom), qd, 16'($urandom),
                   16'($urandom), 16'($urandom));
    endtask

    task automatic add_rand_bytes(input int n);
        for (int k = 0; k < n; k++) pkt_buf.push_back(8'($urandom_range(255)));
    endtask

    // queue the built payload, cut to keep bytes when 0 < keep < size
    task automatic send_packet(input int keep);
        int        n;
        t_pay_byte pb;
        n = (keep > 0 && keep < pkt_buf.size()) ? keep : pkt_buf.size();
        for (int k = 0; k < n; k++) begin
            pb.data = pkt_buf[k];
            pb.lst  = (k == n - 1);
            pending_bytes.push_back(pb);
            n_pushed++;
        end
        pkt_buf.delete();
    endtask

    function automatic logic [15:0] rand_qd();
        return ($urandom_range(1) != 0) ? 16'd1 : 16'($urandom_range(65535, 1));
    endfunction

    // one random payload; well-formed questions dominate
    task automatic rand_packet;
        int sel;
        int nlab;
        int len;
        int total;
        int keep;
        sel  = $urandom_range(99);
        keep = 0;
        if (sel < 10) begin
            // short header
            add_rand_bytes($urandom_range(11, 1));
        end else if (sel < 20) begin
            // no question, trailing bytes ignored
            add_rand_header(16'h0000);
            add_rand_bytes($urandom_range(6));
        end else if (sel < 25) begin
            // empty name
            add_rand_header(rand_qd());
            pkt_buf.push_back(8'h00);
            add_rand_bytes($urandom_range(4));
        end else if (sel < 29) begin
            // name near the length limit, either just fits or just fails
            add_rand_header(rand_qd());
            total = 0;
            while (total + 64 < 200) begin
                len = $urandom_range(63, 40);
                pkt_buf.push_back(8'(len));
                add_rand_bytes(len);
                total += len + 1;
            end
            len = ($urandom_range(1) != 0) ? 254 - total : 255 - total;
            pkt_buf.push_back(8'(len));
            add_rand_bytes(len);
            pkt_buf.push_back(8'h00);
            add_rand_bytes(4);
            if ($urandom_range(4) == 0) keep = $urandom_range(pkt_buf.size() - 1, 1);
        end else if (sel < 39) begin
            // noise
            add_rand_bytes($urandom_range(40, 1));
        end else begin
            // well-formed question, sometimes cut short
            add_rand_header(rand_qd());
            nlab = $urandom_range(4, 1);
            for (int k = 0; k < nlab; k++) begin
                len = $urandom_range(15, 1);
                pkt_buf.push_back(8'(len));
                add_rand_bytes(len);
            end
            pkt_buf.push_back(8'h00);
            add_rand_bytes(4 + $urandom_range(3));
            if ($urandom_range(3) == 0) keep = $urandom_range(pkt_buf.size() - 1, 1);
        end
        send_packet(keep);
    endtask

    // sender holds off until all queued bytes went in and all words came out
    task automatic wait_drained;
        while (pending_bytes.size() != 0 || s_axis_tvalid || expected_words.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int idle_tab[4];
        int stall_tab[4];
        int target;
        idle_tab  = '{0, 64, 0, 36};
        stall_tab = '{0, 0, 64, 36};
        clear_parse();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_tab[ph];
            stall_pct     = stall_tab[ph];
            if (ph == 0) begin
                // short header: a single byte
                pkt_buf.push_back(8'hFF);
                send_packet(0);
                // header alone, no question
                add_header(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
                send_packet(0);
                // empty name
                add_header(16'h0000, 16'hFFFF, 16'h0001, 16'h0000, 16'hFFFF, 16'h0000);
                pkt_buf.push_back(8'h00);
                send_packet(0);
                // first label too long for the name limit
                add_header(16'h8001, 16'h8180, 16'hFFFF, 16'h0001, 16'h0002, 16'h0003);
                pkt_buf.push_back(8'hFF);
                send_packet(0);
                // pointer byte taken as a label length, payload ends inside it
                add_header(16'h1234, 16'h0100, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
                pkt_buf.push_back(8'hC0);
                pkt_buf.push_back(8'h0C);
                send_packet(0);
                // two labels, type and class, one trailing byte
                add_header(16'hABCD, 16'h0120, 16'h0001, 16'h0000, 16'h0000, 16'h0001);
                pkt_buf.push_back(8'h01);
                pkt_buf.push_back(8'h61);
                pkt_buf.push_back(8'h01);
                pkt_buf.push_back(8'h62);
                pkt_buf.push_back(8'h00);
                add16(16'hFFFF);
                add16(16'h0001);
                pkt_buf.push_back(8'h5A);
                send_packet(0);
            end
            target = n_pushed + RAND_PER_PHASE;
            while (n_pushed < target) rand_packet();
            wait_drained();
        end

        if (n_errors == 0)
            $display("dns_header_question_parser_top regression: pass");
        else
            $display("dns_header_question_parser_top regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver: presents one byte word at a time, models each accepted byte
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            s_axis_tlast  <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                parse_byte(cur_byte.data, cur_byte.lst);
            // load the next word once the current one is gone
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_byte = pending_bytes.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= cur_byte.data;
                    s_axis_tlast  <= cur_byte.lst;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: random back-pressure, compare each output word
    // ------------------------------------------------------------------------
    task automatic check_field(input string fname, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            n_errors++;
            $error("%s mismatch: expected 0x%04h, got 0x%04h", fname, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_dns_word w;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_words.size() == 0) begin
                    n_errors++;
                    $error("output word with none expected: tdata 0x%h tlast %b",
                           m_axis_tdata, m_axis_tlast);
                end else begin
                    w = expected_words.pop_front();
                    check_field("kind", 16'(w.kind), 16'(m_axis_tlast));
                    check_field("name_char", 16'(w.ch), 16'(m_axis_tdata[7:0]));
                    check_field("ident", w.ident, m_axis_tdata[23:8]);
                    check_field("hdr_flags", w.flags, m_axis_tdata[39:24]);
                    check_field("question_count", w.qd, m_axis_tdata[55:40]);
                    check_field("answer_count", w.an, m_axis_tdata[71:56]);
                    check_field("authority_count", w.ns, m_axis_tdata[87:72]);
                    check_field("additional_count", w.ar, m_axis_tdata[103:88]);
                    check_field("query_type", w.qtype, m_axis_tdata[119:104]);
                    check_field("query_class", w.qclass, m_axis_tdata[135:120]);
                    check_field("status", 16'(w.st), 16'(m_axis_tdata[137:136]));
                    check_field("packet_length", w.plen, m_axis_tdata[153:138]);
                end
            end
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("dns_header_question_parser_top regression: fail");
            $finish;
        end
    end

endmodule
